// File: hdl/hrhp_pkg.sv
`timescale 1ns / 1ps
package hrhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hrhp_in_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  status_code;
    logic [1:0]  framing;
    logic [63:0] content_length;
    logic        interim;
    logic        connection_close;
  } hrhp_out_t;

  localparam logic [1:0] FRAME_NONE    = 2'd0;
  localparam logic [1:0] FRAME_CHUNKED = 2'd1;
  localparam logic [1:0] FRAME_LENGTH  = 2'd2;
  localparam logic [1:0] FRAME_CLOSE   = 2'd3;

endpackage

// File: hdl/http_response_head_parser_core.sv
`timescale 1ns / 1ps
// HTTP/1.x response head parser.
// Input channel: one word per byte of the head (data_byte, last_byte), taken
// when in_valid_i is high and in_stall_o is low. Output channel: one word per
// head, presented on the byte that carries last_byte, held while out_stall_i
// is high. Configuration channel: cfg_valid_i/cfg_ready_o write max_body_size;
// write only while the parser is idle.
// The result appears, registered, in the cycle after the last byte is taken.
// Throughput: one byte per cycle when not stalled; the whole per-byte step
// is a single registered stage, bounded by the 64-bit times-ten add and
// overflow check. Bytes that close no head produce no word.
// Reset clears the parse state and the output valid, and loads max_body_size
// with 16777216. After each result the parse state returns to its reset value.
// While a result waits under stall, further input is stalled too, so no word
// is lost; once the result is taken input flows again in the same cycle.
module http_response_head_parser_core
  import hrhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  hrhp_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output hrhp_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);

  localparam logic [2:0] PH_STATUS = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_FIELD  = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [2:0] FP_NAME      = 3'd0;
  localparam logic [2:0] FP_NAME_WS   = 3'd1;
  localparam logic [2:0] FP_VAL_LEAD  = 3'd2;
  localparam logic [2:0] FP_VAL       = 3'd3;
  localparam logic [2:0] FP_VAL_TRAIL = 3'd4;

  localparam logic [2:0] NAME_CL   = 3'd1;
  localparam logic [2:0] NAME_TE   = 3'd2;
  localparam logic [2:0] NAME_CONN = 3'd4;

  localparam logic [8*14-1:0] TXT_CL    = "content-length";
  localparam logic [8*17-1:0] TXT_TE    = "transfer-encoding";
  localparam logic [8*10-1:0] TXT_CONN  = "connection";
  localparam logic [8*7-1:0]  TXT_CHUNK = "chunked";
  localparam logic [8*8-1:0]  TXT_IDENT = "identity";
  localparam logic [8*5-1:0]  TXT_CLOSE = "close";
  localparam logic [8*7-1:0]  TXT_HTTP  = "HTTP/1.";

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  pos;
    logic [9:0]  code;
    logic        held;
    logic [2:0]  ncand;
    logic [2:0]  vcand;
    logic [4:0]  midx;
    logic [2:0]  fpart;
    logic [63:0] num;
    logic [63:0] saved;
    logic        have_len;
    logic        chunked;
    logic        close_seen;
    logic        failed;
  } hrhp_state_t;

  localparam hrhp_state_t STATE_RESET = '{
    phase: PH_STATUS, pos: 4'd0, code: 10'd0, held: 1'b0, ncand: 3'b111,
    vcand: 3'b111, midx: 5'd0, fpart: FP_NAME, num: 64'd0, saved: 64'd0,
    have_len: 1'b0, chunked: 1'b0, close_seen: 1'b0, failed: 1'b0};

  function automatic logic [7:0] lower(input logic [7:0] c);
    lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_ows(input logic [7:0] c);
    is_ows = (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] name_ch(input int k, input logic [4:0] i);
    name_ch = 8'h00;
    unique case (k)
      0: if (i < 5'd14) name_ch = TXT_CL[8*(13 - i) +: 8];
      1: if (i < 5'd17) name_ch = TXT_TE[8*(16 - i) +: 8];
      default: if (i < 5'd10) name_ch = TXT_CONN[8*(9 - i) +: 8];
    endcase
  endfunction

  function automatic logic [7:0] val_ch(input int k, input logic [4:0] i);
    val_ch = 8'h00;
    unique case (k)
      0: if (i < 5'd7) val_ch = TXT_CHUNK[8*(6 - i) +: 8];
      1: if (i < 5'd8) val_ch = TXT_IDENT[8*(7 - i) +: 8];
      default: if (i < 5'd5) val_ch = TXT_CLOSE[8*(4 - i) +: 8];
    endcase
  endfunction

  function automatic hrhp_state_t narrow_step(input hrhp_state_t s, input logic is_val,
                                              input logic [7:0] c);
    hrhp_state_t r;
    logic [7:0]  lc;
    logic [7:0]  t;
    r  = s;
    lc = lower(c);
    for (int k = 0; k < 3; k++) begin
      t = is_val ? val_ch(k, s.midx) : name_ch(k, s.midx);
      if (t == 8'h00 || t != lc) begin
        if (is_val) r.vcand[k] = 1'b0;
        else r.ncand[k] = 1'b0;
      end
    end
    if (s.midx != 5'd31) r.midx = s.midx + 5'd1;
    narrow_step = r;
  endfunction

  function automatic hrhp_state_t resolve(input hrhp_state_t s);
    hrhp_state_t r;
    r = s;
    if (s.midx != 5'd14) r.ncand[0] = 1'b0;
    if (s.midx != 5'd17) r.ncand[1] = 1'b0;
    if (s.midx != 5'd10) r.ncand[2] = 1'b0;
    r.fpart = FP_VAL_LEAD;
    r.vcand = 3'b111;
    r.midx  = 5'd0;
    r.num   = 64'd0;
    resolve = r;
  endfunction

  function automatic hrhp_state_t value_char(input hrhp_state_t s, input logic [7:0] c);
    hrhp_state_t r;
    logic [67:0] prod;
    r = s;
    if (s.ncand == NAME_CL) begin
      prod = {1'b0, s.num, 3'b000} + {3'b000, s.num, 1'b0} + {60'd0, c - CH_ZERO};
      if (!is_digit(c) || prod[67:64] != 4'd0) r.failed = 1'b1;
      else r.num = prod[63:0];
    end else begin
      r = narrow_step(s, 1'b1, c);
    end
    value_char = r;
  endfunction

  function automatic hrhp_state_t field_byte(input hrhp_state_t s, input logic [7:0] c);
    hrhp_state_t r;
    r = s;
    unique case (s.fpart)
      FP_NAME: begin
        if (c == CH_COLON) r = resolve(s);
        else if (is_ows(c)) r.fpart = FP_NAME_WS;
        else r = narrow_step(s, 1'b0, c);
      end
      FP_NAME_WS: begin
        if (c == CH_COLON) r = resolve(s);
        else if (!is_ows(c)) begin
          r.ncand = 3'b000;
          r.fpart = FP_NAME;
        end
      end
      FP_VAL_LEAD: begin
        if (!is_ows(c)) begin
          r.fpart = FP_VAL;
          r = value_char(r, c);
        end
      end
      FP_VAL: begin
        if (is_ows(c)) r.fpart = FP_VAL_TRAIL;
        else r = value_char(s, c);
      end
      default: begin
        if (!is_ows(c)) begin
          r.vcand = 3'b000;
          if (s.ncand == NAME_CL) r.failed = 1'b1;
          r.fpart = FP_VAL;
        end
      end
    endcase
    field_byte = r;
  endfunction

  function automatic hrhp_state_t take(input hrhp_state_t s, input logic [7:0] c);
    hrhp_state_t r;
    r = s;
    if (!s.failed) begin
      if (s.phase == PH_STATUS) begin
        if (s.pos < 4'd7) begin
          if (c != TXT_HTTP[8*(6 - s.pos[2:0]) +: 8]) r.failed = 1'b1;
        end else if (s.pos == 4'd7) begin
          if (!is_digit(c)) r.failed = 1'b1;
        end else if (s.pos == 4'd8 || s.pos == 4'd12) begin
          if (c != CH_SP) r.failed = 1'b1;
        end else if (s.pos <= 4'd11) begin
          if (!is_digit(c)) r.failed = 1'b1;
          else r.code = 10'((s.code << 3) + (s.code << 1) + {2'b00, c - CH_ZERO});
        end
        if (s.pos != 4'd13) r.pos = s.pos + 4'd1;
      end else if (s.phase == PH_START) begin
        if (is_ows(c)) r.phase = PH_SKIP;
        else begin
          r.phase = PH_FIELD;
          r.ncand = 3'b111;
          r.midx  = 5'd0;
          r.fpart = FP_NAME;
          r = field_byte(r, c);
        end
      end else if (s.phase == PH_FIELD) begin
        r = field_byte(s, c);
      end
    end
    take = r;
  endfunction

  function automatic hrhp_state_t end_line(input hrhp_state_t s);
    hrhp_state_t r;
    r = s;
    if (!s.failed) begin
      unique case (s.phase)
        PH_STATUS: begin
          if (s.pos < 4'd12) r.failed = 1'b1;
          r.phase = PH_START;
        end
        PH_START: r.phase = PH_DONE;
        PH_SKIP:  r.phase = PH_START;
        PH_FIELD: begin
          r.phase = PH_START;
          if (s.fpart <= FP_NAME_WS) r.failed = 1'b1;
          else if (s.ncand == NAME_CL) begin
            if (s.fpart == FP_VAL_LEAD) r.failed = 1'b1;
            else if (s.have_len && s.num != s.saved) r.failed = 1'b1;
            else begin
              r.have_len = 1'b1;
              r.saved    = s.num;
            end
          end else if (s.ncand == NAME_TE) begin
            if (s.fpart != FP_VAL_LEAD) begin
              if (s.vcand[0] && s.midx == 5'd7) r.chunked = 1'b1;
              else if (!(s.vcand[1] && s.midx == 5'd8)) r.failed = 1'b1;
            end
          end else if (s.ncand == NAME_CONN) begin
            if (s.fpart != FP_VAL_LEAD && s.vcand[2] && s.midx == 5'd5)
              r.close_seen = 1'b1;
          end
        end
        default: ;
      endcase
    end
    end_line = r;
  endfunction

  function automatic hrhp_state_t feed(input hrhp_state_t s, input logic [7:0] c);
    hrhp_state_t r;
    r = s;
    if (c == CH_CR) r.held = 1'b1;
    else if (c == CH_LF) r = end_line(s);
    else r = take(s, c);
    feed = r;
  endfunction

  hrhp_state_t st_q, st_d;
  logic [63:0] max_body_q;
  logic        out_valid_q;
  hrhp_out_t   out_q, out_d;
  logic        emit;
  logic        in_fire;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    hrhp_state_t s;
    s     = st_q;
    out_d = '0;
    emit  = 1'b0;
    if (s.held) begin
      s.held = 1'b0;
      if (in_data_i.data_byte == CH_LF) s = end_line(s);
      else s = feed(take(s, CH_CR), in_data_i.data_byte);
    end else begin
      s = feed(s, in_data_i.data_byte);
    end
    st_d = s;
    if (in_data_i.last_byte) begin
      emit = 1'b1;
      if (s.held) begin
        s.held = 1'b0;
        s = take(s, CH_CR);
      end
      if (s.phase == PH_STATUS || s.phase == PH_FIELD || s.phase == PH_SKIP)
        s = end_line(s);
      if (!s.failed) begin
        if (s.code >= 10'd100 && s.code < 10'd200) out_d.interim = 1'b1;
        else if (s.code == 10'd204 || s.code == 10'd304) out_d.framing = FRAME_NONE;
        else if (s.chunked) out_d.framing = FRAME_CHUNKED;
        else if (s.have_len) begin
          if (s.saved > max_body_q) s.failed = 1'b1;
          else begin
            out_d.framing        = FRAME_LENGTH;
            out_d.content_length = s.saved;
          end
        end else out_d.framing = FRAME_CLOSE;
      end
      if (s.failed) out_d = '0;
      else begin
        out_d.ok               = 1'b1;
        out_d.status_code      = s.code;
        out_d.connection_close = s.close_seen;
      end
      st_d = STATE_RESET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= STATE_RESET;
      max_body_q  <= 64'd16777216;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) st_q <= st_d;
      if (cfg_valid_i) max_body_q <= cfg_data_i;
      if (in_fire) out_valid_q <= emit;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) out_q <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.status_code == 10'd0 &&
      out_data_o.framing == FRAME_NONE && out_data_o.content_length == 64'd0)
    else $error("failed head carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.framing != FRAME_LENGTH |-> out_data_o.content_length == 64'd0)
    else $error("length without length framing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.interim |-> out_data_o.framing == FRAME_NONE)
    else $error("interim response with body framing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_byte |=> st_q == STATE_RESET && out_valid_o)
    else $error("state not cleared after result");

endmodule

// File: test/http_response_head_parser_core_tb.sv
`timescale 1ns / 1ps
module http_response_head_parser_core_tb;
  import hrhp_pkg::*;

  localparam int STALL_LIMIT = 20000;

  localparam logic [2:0] PH_STATUS = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_FIELD  = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] FP_NAME      = 3'd0;
  localparam logic [2:0] FP_NAME_WS   = 3'd1;
  localparam logic [2:0] FP_VAL_LEAD  = 3'd2;
  localparam logic [2:0] FP_VAL       = 3'd3;
  localparam logic [2:0] FP_VAL_TRAIL = 3'd4;
  localparam logic [2:0] NM_CL   = 3'd1;
  localparam logic [2:0] NM_TE   = 3'd2;
  localparam logic [2:0] NM_CONN = 3'd4;
  localparam logic [2:0] VL_CHUNKED  = 3'd1;
  localparam logic [2:0] VL_IDENTITY = 3'd2;
  localparam logic [2:0] VL_CLOSE    = 3'd4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  hrhp_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  hrhp_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i = '0;

  http_response_head_parser_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  hrhp_in_t  byte_q[$];
  hrhp_out_t head_q[$];
  int        errors = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_off = 0;
  int        quiet = 0;
  string     status_pfx = "HTTP/1.";

  // predictor state
  logic [63:0] max_body;
  logic [2:0]  ph;
  logic [4:0]  pos;
  logic [9:0]  code;
  logic        held_cr;
  logic [2:0]  name_c, val_c;
  logic [4:0]  midx;
  logic [2:0]  fpart;
  logic [63:0] num, saved;
  logic        have_len, chunked, closed, bad;

  function automatic logic [7:0] lc(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic ows(logic [7:0] c);
    return c == " " || c == 8'h09;
  endfunction

  function automatic logic dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_head();
    ph = PH_STATUS; pos = 0; code = 0; held_cr = 0; name_c = 3'b111; val_c = 3'b111;
    midx = 0; fpart = FP_NAME; num = 0; saved = 0; have_len = 0; chunked = 0;
    closed = 0; bad = 0;
  endtask

  function automatic logic [2:0] narrow_names(logic [2:0] cand, logic [7:0] c, logic is_val);
    string words[3];
    int k;
    if (is_val) begin
      words[0] = "chunked"; words[1] = "identity"; words[2] = "close";
    end else begin
      words[0] = "content-length"; words[1] = "transfer-encoding"; words[2] = "connection";
    end
    for (k = 0; k < 3; k++)
      if (cand[k] && (midx >= words[k].len() || words[k][midx] != lc(c))) cand[k] = 1'b0;
    return cand;
  endfunction

  task automatic bump_idx();
    if (midx < 5'd31) midx++;
  endtask

  task automatic end_name();
    if (midx != 14) name_c[0] = 0;
    if (midx != 17) name_c[1] = 0;
    if (midx != 10) name_c[2] = 0;
    fpart = FP_VAL_LEAD; val_c = 3'b111; midx = 0; num = 0;
  endtask

  task automatic value_char(logic [7:0] c);
    logic [63:0] d;
    if (name_c == NM_CL) begin
      if (!dig(c)) begin
        bad = 1;
        return;
      end
      d = c - "0";
      if (num > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) begin
        bad = 1;
        return;
      end
      num = num * 10 + d;
    end else begin
      val_c = narrow_names(val_c, c, 1);
      bump_idx();
    end
  endtask

  task automatic field_char(logic [7:0] c);
    case (fpart)
      FP_NAME: begin
        if (c == ":") end_name();
        else if (ows(c)) fpart = FP_NAME_WS;
        else begin
          name_c = narrow_names(name_c, c, 0);
          bump_idx();
        end
      end
      FP_NAME_WS: begin
        if (c == ":") end_name();
        else if (!ows(c)) begin
          name_c = 0; fpart = FP_NAME;
        end
      end
      FP_VAL_LEAD: begin
        if (!ows(c)) begin
          fpart = FP_VAL; value_char(c);
        end
      end
      FP_VAL: begin
        if (ows(c)) fpart = FP_VAL_TRAIL;
        else value_char(c);
      end
      default: begin
        if (!ows(c)) begin
          val_c = 0;
          if (name_c == NM_CL) bad = 1;
          fpart = FP_VAL;
        end
      end
    endcase
  endtask

  task automatic take_char(logic [7:0] c);
    if (bad) return;
    if (ph == PH_STATUS) begin
      if (pos < 7) begin
        if (c != status_pfx[pos]) bad = 1;
      end else if (pos == 7) begin
        if (!dig(c)) bad = 1;
      end else if (pos == 8 || pos == 12) begin
        if (c != " ") bad = 1;
      end else if (pos <= 11) begin
        if (!dig(c)) bad = 1;
        else code = code * 10 + (c - "0");
      end
      if (pos < 13) pos++;
    end else if (ph == PH_START) begin
      if (ows(c)) ph = PH_SKIP;
      else begin
        ph = PH_FIELD; name_c = 3'b111; midx = 0; fpart = FP_NAME;
        field_char(c);
      end
    end else if (ph == PH_FIELD) begin
      field_char(c);
    end
  endtask

  task automatic close_line();
    if (bad) return;
    case (ph)
      PH_STATUS: begin
        if (pos < 12) bad = 1;
        ph = PH_START;
      end
      PH_START: ph = PH_DONE;
      PH_SKIP: ph = PH_START;
      PH_FIELD: begin
        ph = PH_START;
        if (fpart <= FP_NAME_WS) bad = 1;
        else if (name_c == NM_CL) begin
          if (fpart == FP_VAL_LEAD) bad = 1;
          else if (have_len && num != saved) bad = 1;
          else begin
            have_len = 1; saved = num;
          end
        end else if (name_c == NM_TE) begin
          if (fpart != FP_VAL_LEAD) begin
            if ((val_c & VL_CHUNKED) != 0 && midx == 7) chunked = 1;
            else if (!((val_c & VL_IDENTITY) != 0 && midx == 8)) bad = 1;
          end
        end else if (name_c == NM_CONN) begin
          if (fpart != FP_VAL_LEAD && (val_c & VL_CLOSE) != 0 && midx == 5) closed = 1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic plain_char(logic [7:0] c);
    if (c == 8'h0D) held_cr = 1;
    else if (c == 8'h0A) close_line();
    else take_char(c);
  endtask

  task automatic predict_byte(hrhp_in_t w);
    hrhp_out_t r;
    if (held_cr) begin
      held_cr = 0;
      if (w.data_byte == 8'h0A) close_line();
      else begin
        take_char(8'h0D); plain_char(w.data_byte);
      end
    end else plain_char(w.data_byte);
    if (!w.last_byte) return;
    if (held_cr) begin
      held_cr = 0; take_char(8'h0D);
    end
    if (ph == PH_STATUS || ph == PH_FIELD || ph == PH_SKIP) close_line();
    r = '0;
    if (!bad) begin
      if (code >= 100 && code < 200) begin
        r.interim = 1; r.framing = FRAME_NONE;
      end else if (code == 204 || code == 304) r.framing = FRAME_NONE;
      else if (chunked) r.framing = FRAME_CHUNKED;
      else if (have_len) begin
        if (saved > max_body) bad = 1;
        else begin
          r.framing = FRAME_LENGTH; r.content_length = saved;
        end
      end else r.framing = FRAME_CLOSE;
    end
    if (bad) r = '0;
    else begin
      r.ok = 1; r.status_code = code; r.connection_close = closed;
    end
    head_q.push_back(r);
    clear_head();
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic push_text(string s, logic last_at_end);
    hrhp_in_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.data_byte = s[i];
      w.last_byte = last_at_end && (i == s.len() - 1);
      byte_q.push_back(w);
    end
  endtask

  function automatic string mix_case(string s);
    string o;
    o = s;
    for (int i = 0; i < o.len(); i++)
      if ($urandom_range(0, 1) && o[i] >= "a" && o[i] <= "z") o[i] = o[i] - 8'd32;
    return o;
  endfunction

  function automatic string rand_digits(int n);
    string o;
    o = "";
    for (int i = 0; i < n; i++) o = {o, string'(byte'("0" + $urandom_range(0, 9)))};
    return o;
  endfunction

  function automatic string eol();
    return $urandom_range(0, 5) == 0 ? string'("\n") : string'("\r\n");
  endfunction

  function automatic string rand_head();
    string h, codes[8], te[5], ln;
    int n;
    codes = '{"100", "200", "204", "304", "404", "199", "999", "000"};
    te = '{"chunked", "identity", "", "gzip", "chunkedx"};
    h = {"HTTP/1.", string'(byte'("0" + $urandom_range(0, 9))), " ",
         $urandom_range(0, 2) ? codes[$urandom_range(0, 7)] : rand_digits(3)};
    if ($urandom_range(0, 1)) h = {h, " OK"};
    h = {h, eol()};
    n = $urandom_range(0, 4);
    ln = $urandom_range(0, 3) == 0 ? rand_digits($urandom_range(1, 21)) :
         $sformatf("%0d", $urandom_range(0, 40000000));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0, 1: h = {h, mix_case("content-length"), ":",
                   $urandom_range(0, 1) ? string'(" ") : string'(""),
                   $urandom_range(0, 7) ? ln : string'("1x"),
                   $urandom_range(0, 3) ? string'("") : string'(" \t"), eol()};
        2: h = {h, mix_case("Transfer-Encoding"), ": ", mix_case(te[$urandom_range(0, 4)]),
                eol()};
        3: h = {h, mix_case("Connection"), ":",
                $urandom_range(0, 1) ? string'("close") : string'("keep-alive"), eol()};
        4: h = {h, " \tfolded", eol()};
        5: h = {h, "X-Thing: v", eol()};
        6: h = {h, "bad header", eol()};
        default: h = {h, "Content-Length :", ln, eol()};
      endcase
    end
    if ($urandom_range(0, 9))
      h = {h, eol(), $urandom_range(0, 1) ? string'("body") : string'("")};
    return h;
  endfunction

  task automatic push_noise(int n);
    hrhp_in_t w;
    for (int i = 0; i < n; i++) begin
      w.data_byte = 8'($urandom_range(0, 255));
      w.last_byte = (i == n - 1);
      byte_q.push_back(w);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_byte(in_data_i);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0 && $urandom_range(0, 99) < send_gap) in_valid_i <= 1'b0;
        else if (byte_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= byte_q.pop_front();
        end else in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (head_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          hrhp_out_t e;
          e = head_q.pop_front();
          if (out_data_o.ok != e.ok) report("ok", out_data_o.ok, e.ok);
          if (out_data_o.status_code != e.status_code)
            report("status_code", out_data_o.status_code, e.status_code);
          if (out_data_o.framing != e.framing) report("framing", out_data_o.framing, e.framing);
          if (out_data_o.content_length != e.content_length)
            report("content_length", out_data_o.content_length, e.content_length);
          if (out_data_o.interim != e.interim) report("interim", out_data_o.interim, e.interim);
          if (out_data_o.connection_close != e.connection_close)
            report("connection_close", out_data_o.connection_close, e.connection_close);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else out_stall_i <= recv_gap > 0 && $urandom_range(0, 99) < recv_gap;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    while (byte_q.size() != 0 || in_valid_i || head_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [63:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    max_body = v;
  endtask

  task automatic random_heads(int nbytes);
    int start;
    start = byte_q.size();
    while (byte_q.size() - start < nbytes) begin
      if ($urandom_range(0, 9) == 0) push_noise($urandom_range(1, 12));
      else push_text(rand_head(), 1);
    end
  endtask

  initial begin
    max_body = 64'd16777216;
    clear_head();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_text("HTTP/1.1 200 OK\r\nContent-Length: 16777216\r\n\r\n", 1);
    push_text("HTTP/1.0 101\nconnection: CLOSE\n", 1);
    push_text("HTTP/1.1 204\r", 1);
    push_text("\n", 1);
    push_text("HTTP/1.1 200 x\r\nTransfer-Encoding: chunked\r\n content-length: 5\r\n\r\n", 1);
    push_text("HTTP/1.1 200\r\nContent-Length: 18446744073709551616\r\n\r\n", 1);
    push_text("HTTP/1.1 304\r\nNoColon\r\n\r\n", 1);
    push_noise(3);
    byte_q.push_back('{8'hFF, 1'b1});
    byte_q.push_back('{8'h00, 1'b1});
    drain();

    write_limit(64'hFFFF_FFFF_FFFF_FFFF);
    push_text("HTTP/1.1 200\r\nContent-Length: 18446744073709551615\r\n\r\n", 1);
    push_text("HTTP/1.1 200\r\ncontent-length:1\r\ncontent-length: 2\r\n\r\n", 1);
    send_gap = 6; recv_gap = 60;
    random_heads(320);
    drain();

    write_limit(64'd0);
    push_text("HTTP/1.1 200\r\ncontent-length: 0\r\n\r\n", 1);
    push_text("HTTP/1.1 200\r\ncontent-length: 1\r\n\r\n", 1);
    send_gap = 60; recv_gap = 6;
    random_heads(320);
    drain();

    write_limit(64'd1000);
    send_gap = 0; recv_gap = 0;
    hold_off = 300;
    random_heads(320);
    drain();

    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: http_response_head_parser_core.f
hdl/hrhp_pkg.sv
hdl/http_response_head_parser_core.sv
test/http_response_head_parser_core_tb.sv
